@@ src/fast_atan2_degrees_assert.svh @@
// Assertion macros for the fast_atan2_degrees block
`ifndef FAST_ATAN2_DEGREES_ASSERT_SVH
`define FAST_ATAN2_DEGREES_ASSERT_SVH

// same-cycle implication, held off during reset
`define FAD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define FAD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, checked through reset
`define FAD_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/fad_pkg.sv @@
package fad_pkg;

    localparam int IN_WIDTH        = 16;
    localparam int RATIO_FRAC_BITS = 14;
    localparam int OUT_WIDTH       = 15;

    localparam int MAG_W     = IN_WIDTH + 1;
    localparam int REM_W     = MAG_W + 1;
    localparam int NUM_W     = IN_WIDTH + 2;
    localparam int QUO_W     = RATIO_FRAC_BITS + 1;
    localparam int NUM_CELLS = QUO_W;
    localparam int SCALE_W   = 12;
    localparam int DIFF_W    = RATIO_FRAC_BITS + 3;
    localparam int PROD_W    = DIFF_W + SCALE_W;

    localparam int S_TDATA_W = ((2 * IN_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((OUT_WIDTH + 7) / 8) * 8;

    localparam logic [SCALE_W-1:0]   DEG64_PER_45   = SCALE_W'(2880);
    localparam logic [OUT_WIDTH-1:0] ANGLE_ZERO_DEN = OUT_WIDTH'(5760);
    localparam int                   ANGLE_LIMIT    = 11520;

    typedef struct packed {
        logic neg_y;
        logic neg_num;
        logic k3;
        logic zero;
    } fad_side_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [MAG_W-1:0] den;
        logic [QUO_W-1:0] quo;
        fad_side_t        side;
    } fad_div_t;

endpackage

@@ src/fad_prep.sv @@
module fad_prep (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [fad_pkg::IN_WIDTH-1:0]   y_value,
    input  logic signed [fad_pkg::IN_WIDTH-1:0]   x_value,
    output logic                                  out_valid,
    output fad_pkg::fad_div_t                     out_word,
    input  logic                                  out_ready
);
    import fad_pkg::*;

    logic                    vld_reg;
    fad_div_t                word_reg;
    fad_div_t                word_next;
    logic signed [NUM_W-1:0] y_ext;
    logic signed [NUM_W-1:0] x_ext;
    logic signed [NUM_W-1:0] ay;
    logic signed [NUM_W-1:0] num;
    logic signed [NUM_W-1:0] den;
    logic signed [NUM_W-1:0] num_abs;

    always_comb begin
        y_ext = NUM_W'(y_value);
        x_ext = NUM_W'(x_value);
        ay    = y_value[IN_WIDTH-1] ? -y_ext : y_ext;
        if (!x_value[IN_WIDTH-1]) begin
            num = x_ext - ay;
            den = x_ext + ay;
        end else begin
            num = x_ext + ay;
            den = ay - x_ext;
        end
        num_abs = num[NUM_W-1] ? -num : num;

        word_next.rem          = $unsigned(num_abs);
        word_next.den          = den[MAG_W-1:0];
        word_next.quo          = '0;
        word_next.side.neg_y   = y_value[IN_WIDTH-1];
        word_next.side.neg_num = num[NUM_W-1];
        word_next.side.k3      = x_value[IN_WIDTH-1];
        word_next.side.zero    = (den == '0);
    end

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_word  = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

endmodule

@@ src/fad_div_cell.sv @@
module fad_div_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  fad_pkg::fad_div_t in_word,
    output logic              out_valid,
    output fad_pkg::fad_div_t out_word,
    input  logic              out_ready
);
    import fad_pkg::*;

    logic             vld_reg;
    fad_div_t         word_reg;
    fad_div_t         word_next;
    logic             ge;
    logic [REM_W-1:0] den_ext;
    logic [REM_W-1:0] rem_sel;

    always_comb begin
        den_ext   = REM_W'(in_word.den);
        ge        = (in_word.rem >= den_ext);
        rem_sel   = ge ? (in_word.rem - den_ext) : in_word.rem;
        word_next = in_word;
        word_next.rem = {rem_sel[REM_W-2:0], 1'b0};
        word_next.quo = {in_word.quo[QUO_W-2:0], ge};
    end

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_word  = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

endmodule

@@ src/fad_post.sv @@
module fad_post (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  fad_pkg::fad_div_t               in_word,
    output logic                            out_valid,
    output logic [fad_pkg::OUT_WIDTH-1:0]   out_angle,
    input  logic                            out_ready
);
    import fad_pkg::*;

    logic                 vld_reg;
    logic [OUT_WIDTH-1:0] angle_reg;
    logic [OUT_WIDTH-1:0] angle_next;
    logic [DIFF_W-1:0]    kval;
    logic [DIFF_W-1:0]    q_ext;
    logic [DIFF_W-1:0]    diff;
    logic [PROD_W-1:0]    prod;
    logic [PROD_W-1:0]    rnd;
    logic [OUT_WIDTH-1:0] mag;

    always_comb begin
        kval  = in_word.side.k3 ? (DIFF_W'(3) << RATIO_FRAC_BITS)
                                : (DIFF_W'(1) << RATIO_FRAC_BITS);
        q_ext = DIFF_W'(in_word.quo);
        diff  = in_word.side.neg_num ? (kval + q_ext) : (kval - q_ext);
        prod  = PROD_W'(diff) * PROD_W'(DEG64_PER_45);
        rnd   = prod + (PROD_W'(1) << (RATIO_FRAC_BITS - 1));
        mag   = rnd[RATIO_FRAC_BITS +: OUT_WIDTH];
        if (in_word.side.zero) begin
            angle_next = ANGLE_ZERO_DEN;
        end else if (in_word.side.neg_y) begin
            angle_next = -mag;
        end else begin
            angle_next = mag;
        end
    end

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_angle = angle_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            angle_reg <= angle_next;
        end
    end

endmodule

@@ src/fast_atan2_degrees.sv @@
// Approximate atan2(y, x) in 1/64 degree, from -11520 to +11520 (-180 to +180 degrees),
// using the linear-ratio approximation; both inputs zero gives +90 degrees. One word is
// taken per cycle while m_tready lets the output drain, and each result passes through a
// prep register that forms the ratio terms, one restoring-division cell per quotient bit
// that produces the ratio, and a post stage that scales and rounds into the output register.
// Every stage holds under back-pressure and empty stages close up, so the throughput is one
// word per cycle whenever m_tready stays high.
`include "fast_atan2_degrees_assert.svh"

module fast_atan2_degrees (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // y_value [15:0], x_value [31:16]
    input  logic [fad_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // angle_deg64 [14:0], zero pad above
    output logic [fad_pkg::M_TDATA_W-1:0]   m_tdata
);
    import fad_pkg::*;

    logic signed [IN_WIDTH-1:0] y_value;
    logic signed [IN_WIDTH-1:0] x_value;
    logic                       stg_valid [NUM_CELLS+1];
    logic                       stg_ready [NUM_CELLS+1];
    fad_div_t                   stg_word  [NUM_CELLS+1];
    logic [OUT_WIDTH-1:0]       angle;
    logic signed [OUT_WIDTH-1:0] angle_s;

    assign y_value = $signed(s_tdata[0 +: IN_WIDTH]);
    assign x_value = $signed(s_tdata[IN_WIDTH +: IN_WIDTH]);

    fad_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .y_value   (y_value),
        .x_value   (x_value),
        .out_valid (stg_valid[0]),
        .out_word  (stg_word[0]),
        .out_ready (stg_ready[0])
    );

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        fad_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[i]),
            .in_ready  (stg_ready[i]),
            .in_word   (stg_word[i]),
            .out_valid (stg_valid[i+1]),
            .out_word  (stg_word[i+1]),
            .out_ready (stg_ready[i+1])
        );
    end

    fad_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (stg_valid[NUM_CELLS]),
        .in_ready  (stg_ready[NUM_CELLS]),
        .in_word   (stg_word[NUM_CELLS]),
        .out_valid (m_tvalid),
        .out_angle (angle),
        .out_ready (m_tready)
    );

    assign m_tdata = {{(M_TDATA_W - OUT_WIDTH){1'b0}}, angle};
    assign angle_s = $signed(angle);

    `FAD_ASSERT_NOW(a_angle_range, aclk, aresetn, m_tvalid,
        (angle_s <= ANGLE_LIMIT) && (angle_s >= -ANGLE_LIMIT), "angle out of range")
    `FAD_ASSERT_NOW(a_empty_accepts, aclk, aresetn, !m_tvalid, s_tready,
        "input stalled while output empty")
    `FAD_ASSERT_NEXT(a_take_fills, aclk, aresetn, s_tvalid && s_tready, stg_valid[0],
        "accepted word lost at entry")
    `FAD_ASSERT_ALWAYS_NEXT(a_reset_empty, aclk, !aresetn, !m_tvalid,
        "output valid after reset")

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import fad_pkg::*;

    typedef struct {
        logic signed [IN_WIDTH-1:0]  y;
        logic signed [IN_WIDTH-1:0]  x;
        logic        [OUT_WIDTH-1:0] angle;
    } angle_word_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [S_TDATA_W-1:0] pair_q[$];
    angle_word_t          angle_q[$];
    logic [S_TDATA_W-1:0] held_pair = '0;
    bit                   pair_held = 1'b0;
    bit                   pair_taken = 1'b0;
    int                   idle_odds = 0;
    int                   tx_gap = 0;
    int                   rx_gap = 0;
    int                   fault_count = 0;

    fast_atan2_degrees dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // y_value [15:0], x_value [31:16]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // angle_deg64 [14:0], zero pad above
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [OUT_WIDTH-1:0] atan2_deg64(logic signed [IN_WIDTH-1:0] y,
                                                         logic signed [IN_WIDTH-1:0] x);
        logic signed [IN_WIDTH+2:0] ay;
        logic signed [IN_WIDTH+2:0] num;
        logic signed [IN_WIDTH+2:0] den;
        logic        [31:0]         num_mag;
        logic        [31:0]         quo;
        logic signed [RATIO_FRAC_BITS+4:0] ratio;
        logic signed [RATIO_FRAC_BITS+4:0] diff;
        logic        [31:0]         scaled;
        logic        [OUT_WIDTH-1:0] mag;
        ay = (y < 0) ? -(IN_WIDTH+3)'(y) : (IN_WIDTH+3)'(y);
        if (x >= 0) begin
            num  = (IN_WIDTH+3)'(x) - ay;
            den  = (IN_WIDTH+3)'(x) + ay;
            diff = (RATIO_FRAC_BITS+5)'(1) <<< RATIO_FRAC_BITS;
        end else begin
            num  = (IN_WIDTH+3)'(x) + ay;
            den  = ay - (IN_WIDTH+3)'(x);
            diff = (RATIO_FRAC_BITS+5)'(3) <<< RATIO_FRAC_BITS;
        end
        if (den == 0)
            return ANGLE_ZERO_DEN;
        num_mag = (num < 0) ? 32'(-num) : 32'(num);
        quo     = (num_mag << RATIO_FRAC_BITS) / 32'(den);
        ratio   = (num < 0) ? -(RATIO_FRAC_BITS+5)'(quo) : (RATIO_FRAC_BITS+5)'(quo);
        diff    = diff - ratio;
        scaled  = 32'(diff) * 32'(DEG64_PER_45);
        mag     = OUT_WIDTH'((scaled + (32'd1 << (RATIO_FRAC_BITS - 1))) >> RATIO_FRAC_BITS);
        return (y < 0) ? -mag : mag;
    endfunction

    // monitor: record accepted words and check results
    always @(posedge aclk) begin
        angle_word_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                want.y     = s_tdata[IN_WIDTH-1:0];
                want.x     = s_tdata[2*IN_WIDTH-1:IN_WIDTH];
                want.angle = atan2_deg64(want.y, want.x);
                angle_q.push_back(want);
                pair_taken = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                if (angle_q.size() == 0) begin
                    fault_count++;
                    $display("%0t: unexpected result, expected none, got angle %0d",
                             $time, $signed(m_tdata[OUT_WIDTH-1:0]));
                end else begin
                    want = angle_q.pop_front();
                    if (m_tdata[OUT_WIDTH-1:0] !== want.angle) begin
                        fault_count++;
                        $display("%0t: y=%0d x=%0d expected angle %0d, got %0d", $time,
                                 want.y, want.x, $signed(want.angle),
                                 $signed(m_tdata[OUT_WIDTH-1:0]));
                    end
                end
            end
        end
    end

    // driver: hold each word until taken, idle in bursts, and drop m_tready in bursts
    always @(negedge aclk) begin
        if (aresetn) begin
            if (pair_taken) begin
                pair_taken = 1'b0;
                pair_held  = 1'b0;
            end
            if (!pair_held && pair_q.size() != 0) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
                    tx_gap = $urandom_range(0, 3);
                end else begin
                    held_pair = pair_q.pop_front();
                    pair_held = 1'b1;
                end
            end
            s_tvalid <= pair_held;
            s_tdata  <= held_pair;

            if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
                rx_gap = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [IN_WIDTH-1:0] small_value();
        return IN_WIDTH'(int'($urandom_range(0, 16)) - 8);
    endfunction

    function automatic logic [S_TDATA_W-1:0] random_pair();
        logic [IN_WIDTH-1:0] y;
        logic [IN_WIDTH-1:0] x;
        y = IN_WIDTH'($urandom);
        x = IN_WIDTH'($urandom);
        case ($urandom_range(0, 9))
            5, 6: begin
                y = small_value();
                x = small_value();
            end
            7: y = small_value();
            8: x = small_value();
            9: begin
                x = ($urandom_range(0, 1) == 0) ? y : -y;
                y = ($urandom_range(0, 1) == 0) ? y : -y;
            end
            default: ;
        endcase
        return {x, y};
    endfunction

    initial begin
        int phase;
        int n;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // {x, y}
        pair_q.push_back({16'sd0,      16'sd0});
        pair_q.push_back({16'sd32767,  16'sd0});
        pair_q.push_back({-16'sd32768, 16'sd0});
        pair_q.push_back({16'sd0,      16'sd32767});
        pair_q.push_back({16'sd0,      -16'sd32768});
        pair_q.push_back({-16'sd32768, -16'sd32768});
        pair_q.push_back({16'sd32767,  16'sd32767});
        pair_q.push_back({-16'sd32768, 16'sd32767});
        pair_q.push_back({16'sd32767,  -16'sd32768});
        pair_q.push_back({16'sd32767,  -16'sd1});
        pair_q.push_back({-16'sd32768, -16'sd1});
        pair_q.push_back({-16'sd32768, 16'sd1});
        pair_q.push_back({-16'sd1,     -16'sd32768});
        pair_q.push_back({16'sd1,      16'sd0});
        pair_q.push_back({-16'sd1,     16'sd0});
        pair_q.push_back({16'sd0,      16'sd1});
        pair_q.push_back({16'sd0,      -16'sd1});
        pair_q.push_back({16'sd5,      16'sd5});
        pair_q.push_back({-16'sd5,     -16'sd5});
        pair_q.push_back({-16'sd3,     16'sd100});
        pair_q.push_back({16'sd1,      -16'sd1});
        pair_q.push_back({-16'sd1,     16'sd1});

        // drain completely before the random part
        while (pair_q.size() != 0 || pair_held || angle_q.size() != 0)
            @(posedge aclk);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: idle_odds = 4;
                1: idle_odds = 0;
                2: idle_odds = 3;
                default: idle_odds = 0;
            endcase
            for (n = 0; n < 125; n++)
                pair_q.push_back(random_pair());
            while (pair_q.size() != 0)
                @(posedge aclk);
        end

        while (pair_held || angle_q.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (fault_count == 0)
            $display("fast_atan2_degrees: match");
        else
            $display("fast_atan2_degrees: mismatch");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("fast_atan2_degrees: mismatch");
        $finish;
    end

endmodule
